### src/vorr_pkg.sv
// vorr_pkg: shared types and constants for the voice oscillator register block
// opcodes, register addresses, waveform constants and the oscillator command struct
// no dependencies
package vorr_pkg;

    localparam int REG_COUNT  = 32;
    localparam int ADDR_W     = 5;
    localparam int BYTE_W     = 8;
    localparam int ACC_W      = 24;
    localparam int LFSR_W     = 23;
    localparam int FREQ_W     = 16;
    localparam int PW_W       = 12;

    // opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // register addresses
    localparam logic [ADDR_W-1:0] ADDR_FREQ_LO = 5'h0E;
    localparam logic [ADDR_W-1:0] ADDR_FREQ_HI = 5'h0F;
    localparam logic [ADDR_W-1:0] ADDR_PW_LO   = 5'h10;
    localparam logic [ADDR_W-1:0] ADDR_PW_HI   = 5'h11;
    localparam logic [ADDR_W-1:0] ADDR_CTRL    = 5'h12;
    localparam logic [ADDR_W-1:0] ADDR_PADX    = 5'h19;
    localparam logic [ADDR_W-1:0] ADDR_PADY    = 5'h1A;
    localparam logic [ADDR_W-1:0] ADDR_OSC     = 5'h1B;
    localparam logic [ADDR_W-1:0] ADDR_ENV     = 5'h1C;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 23'h7FFFF8;
    localparam int                EDGE_BIT  = 19;

    // control byte bits
    localparam int CTRL_NOISE    = 7;
    localparam int CTRL_PULSE    = 6;
    localparam int CTRL_SAW      = 5;
    localparam int CTRL_TRIANGLE = 4;

    // what the output stage returns for a beat
    typedef enum logic [2:0] {
        RES_ZERO = 3'b001,
        RES_OSC  = 3'b010,
        RES_PAD  = 3'b100
    } res_kind_t;

    typedef struct packed {
        logic              tick;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } osc_cmd_t;

endpackage

### src/vorr_ram.sv
// vorr_ram: generic single-port synchronous ram with registered read
// no dependencies
module vorr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/vorr_osc.sv
// vorr_osc: voice-3 phase accumulator, noise lfsr, control shadows and waveform select
// depends on vorr_pkg
module vorr_osc (
    input  logic                      clk,
    input  logic                      rst_n,
    input  vorr_pkg::osc_cmd_t        cmd,
    output logic [vorr_pkg::BYTE_W-1:0] osc_byte
);

    logic [vorr_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [vorr_pkg::LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [vorr_pkg::BYTE_W-1:0] freq_lo_reg, freq_hi_reg, pw_lo_reg, pw_hi_reg, ctrl_reg;
    logic [vorr_pkg::ACC_W-1:0]  acc_sum;
    logic [vorr_pkg::FREQ_W-1:0] step;
    logic [vorr_pkg::PW_W-1:0]   width;
    logic [vorr_pkg::PW_W-1:0]   phase_hi;
    logic [vorr_pkg::BYTE_W-1:0] top;

    assign step    = {freq_hi_reg, freq_lo_reg};
    assign acc_sum = acc_reg + {{(vorr_pkg::ACC_W-vorr_pkg::FREQ_W){1'b0}}, step};

    always_comb
    begin
        acc_next  = acc_reg;
        lfsr_next = lfsr_reg;
        if (cmd.tick)
        begin
            acc_next = acc_sum;
            // lfsr clocks on a rising edge of accumulator bit 19
            if (!acc_reg[vorr_pkg::EDGE_BIT] && acc_sum[vorr_pkg::EDGE_BIT])
            begin
                lfsr_next = {lfsr_reg[0] ^ lfsr_reg[2], lfsr_reg[vorr_pkg::LFSR_W-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            lfsr_reg    <= vorr_pkg::LFSR_SEED;
            freq_lo_reg <= '0;
            freq_hi_reg <= '0;
            pw_lo_reg   <= '0;
            pw_hi_reg   <= '0;
            ctrl_reg    <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            lfsr_reg <= lfsr_next;
            if (cmd.wr)
            begin
                case (cmd.addr)
                    vorr_pkg::ADDR_FREQ_LO: freq_lo_reg <= cmd.data;
                    vorr_pkg::ADDR_FREQ_HI: freq_hi_reg <= cmd.data;
                    vorr_pkg::ADDR_PW_LO:   pw_lo_reg   <= cmd.data;
                    vorr_pkg::ADDR_PW_HI:   pw_hi_reg   <= cmd.data;
                    vorr_pkg::ADDR_CTRL:    ctrl_reg    <= cmd.data;
                    default:                ;
                endcase
            end
        end
    end

    assign width    = {pw_hi_reg[3:0], pw_lo_reg};
    assign phase_hi = acc_reg[vorr_pkg::ACC_W-1 -: vorr_pkg::PW_W];
    assign top      = acc_reg[vorr_pkg::ACC_W-1 -: vorr_pkg::BYTE_W];

    always_comb
    begin
        if (ctrl_reg[vorr_pkg::CTRL_NOISE])
        begin
            osc_byte = lfsr_reg[15:8];
        end
        else if (ctrl_reg[vorr_pkg::CTRL_SAW])
        begin
            osc_byte = top;
        end
        else if (ctrl_reg[vorr_pkg::CTRL_TRIANGLE])
        begin
            osc_byte = acc_reg[vorr_pkg::ACC_W-1] ? ~top : top;
        end
        else if (ctrl_reg[vorr_pkg::CTRL_PULSE])
        begin
            osc_byte = (phase_hi < width) ? 8'hFF : 8'h00;
        end
        else
        begin
            osc_byte = '0;
        end
    end

endmodule

### src/voice_oscillator_register_readback.sv
// voice oscillator register readback: 32-byte sound-chip register file with live voice-3
// oscillator readback. input beats carry opcode, reg_address and write_data; every accepted
// beat produces exactly one output beat carrying read_data, in order.
// a read of 0x1B returns the waveform byte (noise, sawtooth, triangle, pulse by control byte
// priority), paddle reads return the stored byte, everything else returns zero.
// writes and ticks take effect at the accepting edge and return zero.
// an accepted beat passes the middle stage (ram read), then the output register.
// throughput: one beat per cycle unless the receiver stalls; the register file ram serves
// one access per cycle; the accumulator add and lfsr shift finish in the accepting cycle.
// in_ready is high whenever the middle stage is empty or moving; a stalled receiver holds
// the output register and then the middle stage, and only then drops in_ready.
// reset: asynchronous, clears the accumulator, seeds the lfsr with 0x7FFFF8, clears the
// control shadows and the per-entry valid bits, so paddle registers read zero until written.
// no clearing pass is needed; in_ready is high as soon as reset is released.
// depends on vorr_pkg, vorr_ram, vorr_osc
module voice_oscillator_register_readback (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [vorr_pkg::ADDR_W-1:0]   reg_address,
    input  logic [vorr_pkg::BYTE_W-1:0]   write_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vorr_pkg::BYTE_W-1:0]   read_data
);

    logic                          accept;
    logic                          is_read, is_write, is_tick;
    logic                          pad_hit;
    logic [vorr_pkg::BYTE_W-1:0]   osc_byte;
    logic [vorr_pkg::BYTE_W-1:0]   ram_rdata;
    vorr_pkg::osc_cmd_t            cmd;
    vorr_pkg::res_kind_t           kind_in;

    // middle stage: waits for the ram read
    logic                          mid_valid_reg;
    vorr_pkg::res_kind_t           mid_kind_reg;
    logic [vorr_pkg::BYTE_W-1:0]   mid_osc_reg;
    logic                          mid_written_reg;
    logic                          mid_adv;

    logic                          out_valid_reg;
    logic [vorr_pkg::BYTE_W-1:0]   out_data_reg, out_data_next;

    logic [vorr_pkg::REG_COUNT-1:0] written_reg;

    assign mid_adv  = mid_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !mid_valid_reg || mid_adv;
    assign accept   = in_valid && in_ready;

    assign is_read  = accept && (opcode == vorr_pkg::OP_READ);
    assign is_write = accept && (opcode == vorr_pkg::OP_WRITE);
    assign is_tick  = accept && (opcode == vorr_pkg::OP_TICK);
    assign pad_hit  = (reg_address == vorr_pkg::ADDR_PADX) ||
                      (reg_address == vorr_pkg::ADDR_PADY);

    always_comb
    begin
        kind_in = vorr_pkg::RES_ZERO;
        if (opcode == vorr_pkg::OP_READ)
        begin
            if (reg_address == vorr_pkg::ADDR_OSC)
            begin
                kind_in = vorr_pkg::RES_OSC;
            end
            else if (pad_hit)
            begin
                kind_in = vorr_pkg::RES_PAD;
            end
        end
    end

    assign cmd.tick = is_tick;
    assign cmd.wr   = is_write;
    assign cmd.addr = reg_address;
    assign cmd.data = write_data;

    vorr_osc u_osc (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .osc_byte (osc_byte)
    );

    // the ram read issues only on an accepted read, so its data holds while the middle stalls
    vorr_ram #(
        .WIDTH (vorr_pkg::BYTE_W),
        .DEPTH (vorr_pkg::REG_COUNT)
    ) u_regs (
        .clk   (clk),
        .we    (is_write),
        .re    (is_read && pad_hit),
        .addr  (reg_address),
        .wdata (write_data),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            mid_kind_reg  <= vorr_pkg::RES_ZERO;
            out_valid_reg <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                mid_valid_reg <= 1'b1;
                mid_kind_reg  <= kind_in;
            end
            else if (mid_adv)
            begin
                mid_valid_reg <= 1'b0;
            end

            if (mid_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (is_write)
            begin
                written_reg[reg_address] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_osc_reg     <= osc_byte;
            mid_written_reg <= written_reg[reg_address];
        end
        if (mid_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        case (mid_kind_reg)
            vorr_pkg::RES_OSC: out_data_next = mid_osc_reg;
            // an entry never written still reads its reset value of zero
            vorr_pkg::RES_PAD: out_data_next = mid_written_reg ? ram_rdata : '0;
            default:           out_data_next = '0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

endmodule
